// File: rtl/unary_rank_symbol_decoder_assert.svh
// Assertion macros used by the decoder back end (urs_back)
`ifndef UNARY_RANK_SYMBOL_DECODER_ASSERT_SVH
`define UNARY_RANK_SYMBOL_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define URS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

`define URS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`else

`define URS_ASSERT(lbl, prop, msg)

`define URS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: rtl/urs_pkg.sv
// Types and constants of the unary rank symbol decoder
`timescale 1ns / 1ps
package urs_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int BYTE_BITS   = 8;
	localparam int NSYM_W      = $clog2(BYTE_BITS + 1);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [NSYM_W-1:0] nsym_t;

	typedef enum logic [1:0] {
		ST_SYMBOL   = 2'd0,
		ST_SIZE_ERR = 2'd1,
		ST_RUN_ERR  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_LOAD,
		PH_DECODE,
		PH_HALT
	} phase_t;

	typedef struct packed {
		nsym_t                     n_sym;
		status_t                   status;
		idx_t [BYTE_BITS-1:0]      ranks;
	} entry_t;

	typedef struct packed {
		logic                 en;
		idx_t                 addr;
		logic [BYTE_BITS-1:0] data;
	} tbl_wr_t;

endpackage

// File: rtl/urs_queue.sv
// Short queue of decoded byte entries between front and back
`timescale 1ns / 1ps
module urs_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  urs_pkg::entry_t push_entry,
	input  logic            pop,
	output urs_pkg::entry_t head,
	output logic            full,
	output logic            empty
);

	urs_pkg::entry_t                 slots_q [urs_pkg::QUEUE_DEPTH];
	logic [urs_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [urs_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [urs_pkg::QCNT_W-1:0]      count_q;

	function automatic logic [urs_pkg::QPTR_W-1:0] ptr_next(
		input logic [urs_pkg::QPTR_W-1:0] p
	);
		if (p == urs_pkg::QPTR_W'(urs_pkg::QUEUE_DEPTH - 1))
			return '0;
		return p + urs_pkg::QPTR_W'(1);
	endfunction

	assign full  = (count_q == urs_pkg::QCNT_W'(urs_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slots_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + urs_pkg::QCNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - urs_pkg::QCNT_W'(1);
		end
	end

endmodule

// File: rtl/urs_front.sv
// Front end: file phase tracking, table load and bit scan of code bytes
`timescale 1ns / 1ps
module urs_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        code_byte,
	input  logic              file_start,
	input  logic              q_full,
	input  logic              q_empty,
	output logic              push,
	output urs_pkg::entry_t   push_entry,
	output urs_pkg::tbl_wr_t tbl_wr
);

	urs_pkg::phase_t phase_q, phase_d;
	urs_pkg::cnt_t   table_count_q, table_count_d;
	urs_pkg::cnt_t   load_index_q, load_index_d;
	urs_pkg::cnt_t   zero_run_q, zero_run_d;
	urs_pkg::cnt_t   load_index_inc;

	logic                                  accept;
	logic                                  size_err;
	urs_pkg::cnt_t                         scan_run;
	urs_pkg::nsym_t                        scan_n;
	logic                                  scan_err;
	urs_pkg::idx_t [urs_pkg::BYTE_BITS-1:0] scan_ranks;

	assign size_err       = ({1'b0, code_byte} > 9'(urs_pkg::TABLE_DEPTH));
	assign load_index_inc = load_index_q + urs_pkg::cnt_t'(1);

	always_comb begin
		logic done;
		done       = 1'b0;
		scan_run   = zero_run_q;
		scan_n     = '0;
		scan_err   = 1'b0;
		scan_ranks = '0;
		for (int b = urs_pkg::BYTE_BITS - 1; b >= 0; b--) begin
			if (!done) begin
				if (code_byte[b]) begin
					if (scan_run >= table_count_q) begin
						scan_err = 1'b1;
						done     = 1'b1;
					end else begin
						scan_ranks[scan_n[2:0]] = scan_run[urs_pkg::IDX_W-1:0];
						scan_n   = scan_n + urs_pkg::nsym_t'(1);
						scan_run = '0;
					end
				end else if (scan_run < urs_pkg::cnt_t'(urs_pkg::TABLE_DEPTH)) begin
					scan_run = scan_run + urs_pkg::cnt_t'(1);
				end
			end
		end
	end

	always_comb begin
		phase_d       = phase_q;
		table_count_d = table_count_q;
		load_index_d  = load_index_q;
		zero_run_d    = zero_run_q;
		if (accept) begin
			if (file_start) begin
				zero_run_d   = '0;
				load_index_d = '0;
				if (size_err) begin
					table_count_d = '0;
					phase_d       = urs_pkg::PH_HALT;
				end else begin
					table_count_d = urs_pkg::cnt_t'(code_byte);
					phase_d       = (code_byte == '0) ? urs_pkg::PH_DECODE : urs_pkg::PH_LOAD;
				end
			end else begin
				unique case (phase_q)
					urs_pkg::PH_LOAD: begin
						load_index_d = load_index_inc;
						if (load_index_inc >= table_count_q)
							phase_d = urs_pkg::PH_DECODE;
					end
					urs_pkg::PH_DECODE: begin
						zero_run_d = scan_run;
						if (scan_err)
							phase_d = urs_pkg::PH_HALT;
					end
					urs_pkg::PH_IDLE, urs_pkg::PH_HALT: begin
					end
				endcase
			end
		end
	end

	always_comb begin
		in_ready = !q_full && !(phase_q == urs_pkg::PH_LOAD && !q_empty);
		accept   = in_valid && in_ready;

		tbl_wr.en   = accept && !file_start && (phase_q == urs_pkg::PH_LOAD);
		tbl_wr.addr = load_index_q[urs_pkg::IDX_W-1:0];
		tbl_wr.data = code_byte;

		push_entry = '0;
		push       = 1'b0;
		if (file_start) begin
			push_entry.n_sym  = '0;
			push_entry.status = urs_pkg::ST_SIZE_ERR;
			push              = accept && size_err;
		end else begin
			push_entry.n_sym  = scan_n;
			push_entry.status = scan_err ? urs_pkg::ST_RUN_ERR : urs_pkg::ST_SYMBOL;
			push_entry.ranks  = scan_ranks;
			push              = accept && (phase_q == urs_pkg::PH_DECODE) &&
				(scan_n != '0 || scan_err);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= urs_pkg::PH_IDLE;
			table_count_q <= '0;
			load_index_q  <= '0;
			zero_run_q    <= '0;
		end else begin
			phase_q       <= phase_d;
			table_count_q <= table_count_d;
			load_index_q  <= load_index_d;
			zero_run_q    <= zero_run_d;
		end
	end

endmodule

// File: rtl/urs_back.sv
// Back end: symbol table, per-result issue, table read and output register
`timescale 1ns / 1ps
`include "unary_rank_symbol_decoder_assert.svh"
module urs_back (
	input  logic              clk,
	input  logic              arst_n,
	input  urs_pkg::entry_t   head,
	input  logic              q_empty,
	output logic              pop,
	input  urs_pkg::tbl_wr_t tbl_wr,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        symbol,
	output logic [1:0]        status
	,
	output logic              last
);

	logic [urs_pkg::BYTE_BITS-1:0] table_mem [urs_pkg::TABLE_DEPTH];

	urs_pkg::nsym_t  k_q;
	urs_pkg::nsym_t  total;
	logic            is_sym;
	logic            last_issue;
	logic            issue;
	logic            s1_adv;
	logic            s2_free;
	logic            err_out;

	logic                          valid_s1;
	urs_pkg::status_t              status_s1;
	logic                          last_s1;
	logic [urs_pkg::BYTE_BITS-1:0] rd_data_s1;

	logic                          out_valid_q;
	logic [7:0]                    symbol_q;
	urs_pkg::status_t              status_q;
	logic                          last_q;

	assign total      = head.n_sym + urs_pkg::nsym_t'(head.status != urs_pkg::ST_SYMBOL);
	assign is_sym     = (k_q < head.n_sym);
	assign last_issue = ((k_q + urs_pkg::nsym_t'(1)) == total);
	assign s2_free    = !out_valid_q || out_ready;
	assign s1_adv     = valid_s1 && s2_free;
	assign issue      = !q_empty && (!valid_s1 || s2_free);
	assign pop        = issue && last_issue;

	always_ff @(posedge clk) begin
		if (tbl_wr.en)
			table_mem[tbl_wr.addr] <= tbl_wr.data;
		if (issue)
			rd_data_s1 <= table_mem[head.ranks[k_q[2:0]]];
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			status_s1 <= is_sym ? urs_pkg::ST_SYMBOL : head.status;
			last_s1   <= last_issue;
		end
		if (s1_adv) begin
			symbol_q <= (status_s1 == urs_pkg::ST_SYMBOL) ? rd_data_s1 : '0;
			status_q <= status_s1;
			last_q   <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop)
				k_q <= '0;
			else if (issue)
				k_q <= k_q + urs_pkg::nsym_t'(1);
			if (issue)
				valid_s1 <= 1'b1;
			else if (s1_adv)
				valid_s1 <= 1'b0;
			if (s2_free)
				out_valid_q <= valid_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign symbol    = symbol_q;
	assign status    = status_q;
	assign last      = last_q;
	assign err_out   = out_valid && (status != urs_pkg::ST_SYMBOL);

	`URS_ASSERT(a_pop_has_item, !pop || !q_empty, "pop from empty queue")
	`URS_ASSERT(a_err_zero, !err_out || symbol == '0, "error item with nonzero symbol")
	`URS_ASSERT(a_err_last, !err_out || last, "error item not last")
	`URS_ASSERT_NEXT(a_k_clear, pop, k_q == '0, "result index not cleared after pop")

endmodule

// File: rtl/unary_rank_symbol_decoder.sv
// Top level of the unary rank symbol decoder
//
// channel  direction  handshake            payload
// in       input      in_valid / in_ready  code_byte, file_start
// out      output     out_valid / out_ready symbol, status, last
//
// The front takes one byte per cycle while ready; the back issues a byte's n results in turn.
// Results leave at one per cycle while out_ready is high, set by the single table read port.
// Table bytes are held off while the queue still has entries from the previous file.
// Reset clears phase, counters and pipeline valids; table contents stay undefined.
// Either side may stall without losing items.
`timescale 1ns / 1ps
module unary_rank_symbol_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] code_byte,
	input  logic       file_start,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] symbol,
	output logic [1:0] status,
	output logic       last
);

	logic              push;
	logic              pop;
	logic              q_full;
	logic              q_empty;
	urs_pkg::entry_t   push_entry;
	urs_pkg::entry_t   head;
	urs_pkg::tbl_wr_t tbl_wr;

	urs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.code_byte  (code_byte),
		.file_start (file_start),
		.q_full     (q_full),
		.q_empty    (q_empty),
		.push       (push),
		.push_entry (push_entry),
		.tbl_wr     (tbl_wr)
	);

	urs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.full       (q_full),
		.empty      (q_empty)
	);

	urs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_empty   (q_empty),
		.pop       (pop),
		.tbl_wr    (tbl_wr),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.symbol    (symbol),
		.status    (status),
		.last      (last)
	);

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the unary rank symbol decoder: predicts each result and checks it
`timescale 1ns / 1ps
module testbench;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int TOTAL_ITEMS  = 110;
	localparam int CALM_END     = 100;
	localparam int HOLD_CYCLES  = 300;

	class decode_scoreboard;
		urs_pkg::phase_t  phase    = urs_pkg::PH_IDLE;
		urs_pkg::cnt_t    tbl_size = '0;
		urs_pkg::cnt_t    load_pos = '0;
		urs_pkg::cnt_t    zeros    = '0;
		logic [7:0]       tbl [urs_pkg::TABLE_DEPTH];
		logic [7:0]       exp_sym [$];
		urs_pkg::status_t exp_st [$];
		logic             exp_last [$];
		int               errors   = 0;

		function int pending();
			return exp_sym.size();
		endfunction

		function void push(logic [7:0] sym, urs_pkg::status_t st, logic lst);
			exp_sym.push_back(sym);
			exp_st.push_back(st);
			exp_last.push_back(lst);
		endfunction

		function void note_byte(logic [7:0] b, logic s);
			int  n;
			bit  stop;
			if (s) begin
				zeros    = '0;
				load_pos = '0;
				if (b > urs_pkg::TABLE_DEPTH) begin
					tbl_size = '0;
					phase    = urs_pkg::PH_HALT;
					push(8'h00, urs_pkg::ST_SIZE_ERR, 1'b1);
				end else begin
					tbl_size = urs_pkg::cnt_t'(b);
					phase    = (b == 8'd0) ? urs_pkg::PH_DECODE : urs_pkg::PH_LOAD;
				end
				return;
			end
			case (phase)
				urs_pkg::PH_LOAD: begin
					tbl[load_pos[urs_pkg::IDX_W-1:0]] = b;
					load_pos = load_pos + 1'b1;
					if (load_pos >= tbl_size)
						phase = urs_pkg::PH_DECODE;
				end
				urs_pkg::PH_DECODE: begin
					n    = 0;
					stop = 1'b0;
					for (int i = 7; i >= 0; i--) begin
						if (!stop) begin
							if (b[i]) begin
								if (zeros >= tbl_size) begin
									push(8'h00, urs_pkg::ST_RUN_ERR, 1'b0);
									phase = urs_pkg::PH_HALT;
									stop  = 1'b1;
								end else begin
									push(tbl[zeros[urs_pkg::IDX_W-1:0]],
										urs_pkg::ST_SYMBOL, 1'b0);
									zeros = '0;
								end
								n++;
							end else if (zeros < urs_pkg::TABLE_DEPTH) begin
								zeros = zeros + 1'b1;
							end
						end
					end
					if (n > 0)
						exp_last[exp_last.size()-1] = 1'b1;
				end
				default: ;
			endcase
		endfunction

		function void check_result(logic [7:0] sym, logic [1:0] st, logic lst);
			logic [7:0]       e_sym;
			urs_pkg::status_t e_st;
			logic             e_last;
			if (exp_sym.size() == 0) begin
				$error("unexpected result: symbol=%0h status=%0d last=%0b", sym, st, lst);
				errors++;
				return;
			end
			e_sym  = exp_sym.pop_front();
			e_st   = exp_st.pop_front();
			e_last = exp_last.pop_front();
			if (sym !== e_sym) begin
				$error("symbol: expected %0h, got %0h", e_sym, sym);
				errors++;
			end
			if (st !== e_st) begin
				$error("status: expected %0d, got %0d", e_st, st);
				errors++;
			end
			if (lst !== e_last) begin
				$error("last: expected %0b, got %0b", e_last, lst);
				errors++;
			end
		endfunction
	endclass

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       in_valid   = 1'b0;
	logic       in_ready;
	logic [7:0] code_byte  = 8'h00;
	logic       file_start = 1'b0;
	logic       out_valid;
	logic       out_ready  = 1'b0;
	logic [7:0] symbol;
	logic [1:0] status;
	logic       last;

	decode_scoreboard sb;
	int  cycles    = 0;
	int  fed_items = 0;
	bit  calm      = 1'b0;
	bit  hold_req  = 1'b0;

	unary_rank_symbol_decoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.code_byte  (code_byte),
		.file_start (file_start),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.symbol     (symbol),
		.status     (status),
		.last       (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(symbol, status, last);
	end

	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_ready <= calm || ($urandom_range(0, 99) >= 15);
			end
		end
	end

	task automatic send_item(input logic [7:0] b, input logic s);
		while (!calm && $urandom_range(0, 99) < 15) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		code_byte  <= b;
		file_start <= s;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_byte(b, s);
		fed_items++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
	endtask

	function automatic int pick_rank(input int size);
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return $urandom_range(size, size + 3);
		if (r < 5)
			return 70;
		return (size > 0) ? $urandom_range(0, size - 1) : 0;
	endfunction

	task automatic play_file(input int size, input int loads, input int codes);
		int         want;
		int         run;
		logic [7:0] b;
		send_item(8'(size), 1'b1);
		for (int i = 0; i < loads; i++)
			send_item(8'($urandom_range(0, 255)), 1'b0);
		run  = 0;
		want = pick_rank(size);
		for (int k = 0; k < codes; k++) begin
			for (int i = 7; i >= 0; i--) begin
				if (run < want) begin
					b[i] = 1'b0;
					run++;
				end else begin
					b[i] = 1'b1;
					run  = 0;
					want = pick_rank(size);
				end
			end
			send_item(b, 1'b0);
		end
	endtask

	initial begin
		int r;
		int size;
		int loads;
		sb = new;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(8'h5A, 1'b0);
		send_item(8'd65, 1'b1);
		send_item(8'hFF, 1'b0);
		send_item(8'd255, 1'b1);
		send_item(8'd0, 1'b1);
		send_item(8'h00, 1'b0);
		send_item(8'h80, 1'b0);
		send_item(8'd2, 1'b1);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h55, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'h01, 1'b0);
		send_item(8'd1, 1'b1);
		send_item(8'hA5, 1'b0);
		send_item(8'h92, 1'b0);
		send_item(8'd3, 1'b1);
		send_item(8'h11, 1'b0);
		send_item(8'd1, 1'b1);
		send_item(8'h22, 1'b0);
		send_item(8'h80, 1'b0);
		send_item(8'd1, 1'b1);
		send_item(8'h33, 1'b0);
		send_item(8'h80, 1'b0);
		wait_drained();

		calm     = 1'b1;
		hold_req = 1'b1;
		play_file(urs_pkg::TABLE_DEPTH, urs_pkg::TABLE_DEPTH, 6);
		while (fed_items < TOTAL_ITEMS) begin
			calm = (fed_items < CALM_END);
			r    = $urandom_range(0, 9);
			if (r == 0) begin
				send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end else begin
				size  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
				loads = size;
				if (size > 0 && $urandom_range(0, 9) == 0)
					loads = $urandom_range(0, size - 1);
				play_file(size, loads, (loads == size) ? $urandom_range(1, 6) : 0);
			end
		end
		calm = 1'b0;
		wait_drained();
		repeat (20) @(posedge clk);

		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

// File: filelist.f
+incdir+rtl
rtl/urs_pkg.sv
rtl/urs_queue.sv
rtl/urs_front.sv
rtl/urs_back.sv
rtl/unary_rank_symbol_decoder.sv
dv/testbench.sv
